>>> design/mm2h_pkg.sv
package mm2h_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'd5381;
    localparam int          QUEUE_DEPTH = 4;

    // APB register indexes
    localparam logic REG_HASH_SEED = 1'b0;

    // One queued command: what the back end does for one input item.
    // load and mix never occur together, so they share data.
    typedef struct packed {
        logic        load;     // data is seed ^ length, replaces running hash
        logic        mix;      // data is a completed word to mix and fold in
        logic        fin;      // finalize and emit after the steps above
        logic        tail_en;  // one to three leftover bytes in tail
        logic [31:0] data;
        logic [23:0] tail;
    } t_cmd;

endpackage

>>> design/mm2h_front.sv
module mm2h_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_seed,
    input  logic              i_valid,
    input  logic [7:0]        i_key_byte,
    input  logic [31:0]       i_key_length,
    input  logic              i_first_item,
    input  logic              i_last_item,
    input  logic              i_empty_key,
    output logic              o_ready,
    input  logic              i_q_full,
    output logic              o_push,
    output mm2h_pkg::t_cmd    o_cmd
);

    logic [1:0]  r_phase, n_phase;
    logic [23:0] r_part,  n_part;
    logic        w_accept;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_phase = i_first_item ? 2'd0  : r_phase;
        n_part  = i_first_item ? 24'd0 : r_part;

        o_cmd.load    = i_first_item;
        o_cmd.mix     = 1'b0;
        o_cmd.fin     = i_last_item;
        o_cmd.tail_en = 1'b0;
        o_cmd.data    = i_seed ^ i_key_length;
        o_cmd.tail    = 24'd0;

        if (!i_empty_key) begin
            unique case (n_phase)
                2'd0: n_part[7:0]   = i_key_byte;
                2'd1: n_part[15:8]  = i_key_byte;
                2'd2: n_part[23:16] = i_key_byte;
                2'd3: begin
                    // word complete, little-endian: this byte is the top one
                    o_cmd.mix  = 1'b1;
                    o_cmd.data = {i_key_byte, n_part};
                    n_part     = 24'd0;
                end
            endcase
            n_phase = n_phase + 2'd1;
        end

        if (i_last_item) begin
            o_cmd.tail_en = (n_phase != 2'd0);
            o_cmd.tail    = n_part;
            n_phase       = 2'd0;
            n_part        = 24'd0;
        end
    end

    // items that neither load, complete a word nor finish leave no command
    assign o_push = w_accept && (o_cmd.load || o_cmd.mix || o_cmd.fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_part  <= 24'd0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_part  <= n_part;
        end
    end

endmodule

>>> design/mm2h_queue.sv
module mm2h_queue #(
    parameter int DEPTH = mm2h_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mm2h_pkg::t_cmd    i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output mm2h_pkg::t_cmd    o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    mm2h_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command popped from empty queue");
`endif

endmodule

>>> design/mm2h_back.sv
module mm2h_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  mm2h_pkg::t_cmd    i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_hash_value
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_K2   = 3'd1;
    localparam logic [2:0] ST_K3   = 3'd2;
    localparam logic [2:0] ST_TAIL = 3'd3;
    localparam logic [2:0] ST_FIN1 = 3'd4;
    localparam logic [2:0] ST_FIN2 = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [31:0] r_hash,  n_hash;
    logic [31:0] r_tmp,   n_tmp;
    logic        r_fin,   n_fin;
    logic        r_tail_en, n_tail_en;
    logic [23:0] r_tail,  n_tail;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out,   n_out;
    logic [31:0] w_op, w_prod, w_final;
    logic        w_slot_free;

    // single shared multiplier by the mix constant
    always_comb begin
        unique case (r_state)
            ST_IDLE: w_op = i_head.data;
            ST_K2:   w_op = r_tmp ^ (r_tmp >> mm2h_pkg::MIX_SHIFT);
            ST_K3:   w_op = r_hash;
            ST_TAIL: w_op = r_hash ^ {8'd0, r_tail};
            ST_FIN1: w_op = r_hash ^ (r_hash >> mm2h_pkg::FIN_SHIFT_A);
            default: w_op = 32'd0;
        endcase
    end

    assign w_prod      = w_op * mm2h_pkg::MIX_MUL;
    assign w_final     = r_hash ^ (r_hash >> mm2h_pkg::FIN_SHIFT_B);
    assign w_slot_free = !r_out_valid || i_ready;
    assign o_pop       = (r_state == ST_IDLE) && i_q_valid;

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_tmp       = r_tmp;
        n_fin       = r_fin;
        n_tail_en   = r_tail_en;
        n_tail      = r_tail;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_tmp     = w_prod;
                    n_fin     = i_head.fin;
                    n_tail_en = i_head.tail_en;
                    n_tail    = i_head.tail;
                    if (i_head.load) begin
                        n_hash = i_head.data;
                    end
                    priority if (i_head.mix) begin
                        n_state = ST_K2;
                    end else if (i_head.fin) begin
                        n_state = i_head.tail_en ? ST_TAIL : ST_FIN1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_K2: begin
                n_tmp   = w_prod;
                n_state = ST_K3;
            end
            ST_K3: begin
                n_hash = w_prod ^ r_tmp;
                priority if (r_fin) begin
                    n_state = r_tail_en ? ST_TAIL : ST_FIN1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_TAIL: begin
                n_hash  = w_prod;
                n_state = ST_FIN1;
            end
            ST_FIN1: begin
                n_hash  = w_prod;
                n_state = ST_FIN2;
            end
            ST_FIN2: begin
                if (w_slot_free) begin
                    n_hash      = w_final;
                    n_out       = w_final;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hash      <= 32'd0;
            r_fin       <= 1'b0;
            r_tail_en   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_fin       <= n_fin;
            r_tail_en   <= n_tail_en;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tmp  <= n_tmp;
        r_tail <= n_tail;
        r_out  <= n_out;
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out;

`ifndef NO_ASSERTIONS
    a_cmd_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_head.load || i_head.mix || i_head.fin))
        else $error("queued command carries no work");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN2) && w_slot_free |=> r_out_valid && (r_state == ST_IDLE))
        else $error("finalized hash not loaded into output register");

    a_tail_excl_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_head.mix |-> !i_head.tail_en && !i_head.load)
        else $error("word mix command with tail or load");
`endif

endmodule

>>> design/murmur2_string_hash.sv
// 32-bit MurmurHash2 over a key streamed one byte per transaction. The first
// transaction of a key (tuser[0]) carries the total length, which is XORed with
// the hash_seed register (APB, address 0, reset 5381) to start the hash; tlast
// ends the key and exactly one 32-bit hash transaction follows. A zero-length
// key is one transaction with tuser[1] (empty) set together with first and
// last. Rate: the front end gathers bytes and takes one byte per cycle while
// its command queue has room. Each completed four-byte word goes through the back
// end states IDLE, K2 and K3 on its single shared 32x32 multiplier, so the back
// end keeps ahead of the byte stream and long keys sustain one byte per cycle,
// with short bursts absorbed by the queue. After the last byte the back end
// finalizes through FIN1 and FIN2 (after TAIL with leftover tail bytes, after
// K2 and K3 when that byte completes a word), plus any command still queued ahead.
// The result sits in an output register, so the next key is accepted while
// the previous hash waits to be taken. Without a new first transaction bytes
// continue from the previous finalized hash.
module murmur2_string_hash #(
    parameter int QUEUE_DEPTH = mm2h_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [7:0] key_byte, [39:8] key_length
    input  logic [1:0]  i_s_tuser,   // [0] first_item, [1] empty_key
    input  logic        i_s_tlast,   // last_item

    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] hash_value

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]    r_seed;
    logic           w_cfg_wr;
    logic           w_q_full, w_push, w_pop, w_q_valid;
    mm2h_pkg::t_cmd w_cmd, w_head;

    // config register; paddr[2] selects the register index
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == mm2h_pkg::REG_HASH_SEED);
    assign prdata   = (paddr[2] == mm2h_pkg::REG_HASH_SEED) ? r_seed : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= mm2h_pkg::SEED_RESET;
        end else if (w_cfg_wr) begin
            r_seed <= pwdata;
        end
    end

    // byte gathering and command building
    mm2h_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_valid      (i_s_tvalid),
        .i_key_byte   (i_s_tdata[7:0]),
        .i_key_length (i_s_tdata[39:8]),
        .i_first_item (i_s_tuser[0]),
        .i_last_item  (i_s_tlast),
        .i_empty_key  (i_s_tuser[1]),
        .o_ready      (o_s_tready),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_cmd        (w_cmd)
    );

    // decouples byte intake from the multiply sequence
    mm2h_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // word mix, fold and finalize on one multiplier
    mm2h_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_hash_value (o_m_tdata)
    );

endmodule
